[hw/rtl/npti_pkg.sv]
// Package for the nearest pair table interpolator.
// Holds the state machine type, status codes and field layout constants.
// Used by nearest_pair_table_interpolator; depends on nothing.
package npti_pkg;

   localparam int unsigned VW       = 48;
   localparam int unsigned NVAL     = 6;
   localparam int unsigned ROWW     = VW * (NVAL + 1);
   localparam int unsigned REQW     = 344;
   localparam int unsigned RSPW     = VW * NVAL;
   localparam int unsigned ADDRW    = 7;
   localparam int unsigned DIVLAST  = 80;
   localparam int unsigned QW       = 63;

   localparam logic [1:0] STATUS_WRITE  = 2'd0;
   localparam logic [1:0] STATUS_INTERP = 2'd1;
   localparam logic [1:0] STATUS_EQUAL  = 2'd2;

   localparam logic [7:0] REG_ROWS_IN_USE   = 8'd0;
   localparam logic [7:0] REG_LENGTH_OFFSET = 8'd1;

   localparam logic [7:0]    ROWS_RESET   = 8'd83;
   localparam logic [VW-1:0] OFFSET_RESET = 48'd9116058;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_READB,
      ST_READS,
      ST_LOADS,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/nearest_pair_table_interpolator.sv]
// Nearest pair table interpolator, top level.
// A beat with tuser 0 writes a table row; status 0 is returned in the next cycle.
// A query beat scans rows 0 to rows_in_use-1 (rows_in_use clamped to 2..TABLE_ROWS)
// through the row memory, one row a cycle, reads the best and second rows, runs a
// restoring divider for the fraction (skipped when the two keys are equal) and six
// 32x32 partial product multiply-accumulate passes, one per output value.
// After reset a clearing pass zeroes every memory row before the first request
// beat is taken. Depends on npti_pkg.
module nearest_pair_table_interpolator
   import npti_pkg::*;
#(
   parameter int unsigned TABLE_ROWS = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // row_address, draught_in, key_displacement, lcf_rel_in, lcb_rel_in,
   // vcb_in, kmt_in, mct_in, zero pad
   input  logic [REQW-1:0] req_tdata,
   // operation
   input  logic            req_tuser,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // draught_out, lcf_out, lcb_out, vcb_out, kmt_out, mct_out
   output logic [RSPW-1:0] rsp_tdata,
   // status
   output logic [1:0]      rsp_tuser,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_index,
   input  logic [VW-1:0]   csr_data
);

   localparam int unsigned AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

   logic [ROWW-1:0] mem [TABLE_ROWS];
   logic [ROWW-1:0] mem_q_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [ROWW-1:0] mem_wdata;
   logic [AW-1:0]   mem_raddr;

   state_type state_ff, state_in;

   logic [7:0]      rows_ff;
   logic [VW-1:0]   offset_ff;
   logic [AW-1:0]   clr_ff;
   logic [AW-1:0]   iss_ff;
   logic            iss_done_ff;
   logic            rd_v_ff;
   logic [AW-1:0]   rd_i_ff;
   logic [AW-1:0]   nlast;
   logic [VW-1:0]   key_ff;
   logic [AW-1:0]   b_ff, s_ff;
   logic [VW-1:0]   kb_ff, ks_ff;
   logic [VW:0]     db_ff, ds_ff;
   logic [RSPW-1:0] vb_ff, vs_ff;
   logic            eq_ff;
   logic            fneg_ff;
   logic [50:0]     r_ff;
   logic [VW:0]     nsh_ff;
   logic [VW:0]     dn_ff;
   logic [QW-1:0]   q_ff;
   logic            ovf_ff;
   logic [6:0]      dcnt_ff;
   logic [2:0]      vidx_ff;
   logic [2:0]      step_ff;
   logic [VW:0]     dvmag_ff;
   logic            dvneg_ff;
   logic [63:0]     pp_ff;
   logic [1:0]      psh_ff;
   logic [112:0]    acc_ff;
   logic [RSPW-1:0] res_ff;
   logic            rsp_v_ff;
   logic [RSPW-1:0] rsp_d_ff;
   logic [1:0]      rsp_u_ff;

   logic            req_acc;
   logic            rsp_free;
   logic            scan_last;
   logic [31:0]     ruse, nrows, wa32;

   // row count and write address
   always_comb begin
      ruse  = 32'(rows_ff);
      nrows = ruse;
      if (ruse < 32'd2) nrows = 32'd2;
      if (ruse > TABLE_ROWS) nrows = TABLE_ROWS;
      nlast = AW'(nrows - 32'd1);
      wa32  = 32'(req_tdata[ADDRW-1:0]);
   end

   assign rsp_free   = !rsp_v_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign scan_last  = rd_v_ff && (rd_i_ff == nlast);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;
   assign rsp_tuser  = rsp_u_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(TABLE_ROWS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_acc && req_tuser) state_in = ST_SCAN;
         ST_SCAN:  if (scan_last) state_in = ST_READB;
         ST_READB: state_in = ST_READS;
         ST_READS: state_in = ST_LOADS;
         ST_LOADS: state_in = (kb_ff == ks_ff) ? ST_MUL : ST_DIV;
         ST_DIV:   if (dcnt_ff == 7'd0) state_in = ST_MUL;
         ST_MUL:   if (step_ff == 3'd6 && vidx_ff == 3'(NVAL - 1)) state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      mem_raddr = iss_ff;
      unique case (state_ff)
         ST_CLEAR: mem_we = 1'b1;
         ST_IDLE: begin
            mem_we    = req_acc && !req_tuser && (wa32 < TABLE_ROWS);
            mem_waddr = wa32[AW-1:0];
            mem_wdata = {req_tdata[ADDRW+VW*ROWW/VW-1:ADDRW+2*VW],
                         req_tdata[ADDRW+VW-1:ADDRW],
                         req_tdata[ADDRW+2*VW-1:ADDRW+VW]};
         end
         ST_READB: mem_raddr = b_ff;
         ST_READS: mem_raddr = s_ff;
         default: mem_raddr = iss_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= mem[mem_raddr];
   end

   // datapath helpers
   logic [VW:0]     key_dist, num, den, dv;
   logic [VW-1:0]   v1, v2, addv;
   logic [50:0]     rt;
   logic            ge, dbit;
   logic [QW-1:0]   fval;
   logic            fneg_eff, neg;
   logic [31:0]     achunk, bchunk;
   logic [112:0]    ppsh;
   logic [62:0]     dmag;
   logic [65:0]     ssum;
   logic [VW-1:0]   sat;

   always_comb begin
      key_dist = $signed({key_ff[VW-1], key_ff})
               - $signed({mem_q_ff[VW-1], mem_q_ff[VW-1:0]});
      if (key_dist[VW]) key_dist = -key_dist;
      num = $signed({key_ff[VW-1], key_ff}) - $signed({kb_ff[VW-1], kb_ff});
      den = $signed({ks_ff[VW-1], ks_ff}) - $signed({kb_ff[VW-1], kb_ff});
      dbit = (dcnt_ff >= 7'd32) ? nsh_ff[VW] : 1'b0;
      rt   = {r_ff[49:0], dbit};
      ge   = rt >= {2'b0, dn_ff};
      fval = ovf_ff ? {QW{1'b1}} : q_ff;
      fneg_eff = fneg_ff && (fval != '0);
      v1   = vb_ff[vidx_ff*VW +: VW];
      v2   = vs_ff[vidx_ff*VW +: VW];
      addv = (vidx_ff == 3'd1 || vidx_ff == 3'd2) ? offset_ff : '0;
      dv   = $signed({v2[VW-1], v2}) - $signed({v1[VW-1], v1});
      achunk = step_ff[0] ? {1'b0, fval[62:32]} : fval[31:0];
      bchunk = step_ff[1] ? {15'b0, dvmag_ff[VW:32]} : dvmag_ff[31:0];
      unique case (psh_ff)
         2'd0:    ppsh = {49'b0, pp_ff};
         2'd1:    ppsh = {17'b0, pp_ff, 32'b0};
         default: ppsh = {pp_ff[48:0], 64'b0};
      endcase
      dmag = (|acc_ff[112:94]) ? {1'b1, 62'b0} : {1'b0, acc_ff[93:32]};
      neg  = fneg_eff ^ dvneg_ff;
      ssum = $signed({{18{v1[VW-1]}}, v1}) + $signed({{18{addv[VW-1]}}, addv});
      ssum = neg ? ssum - {3'b0, dmag} : ssum + {3'b0, dmag};
      if ($signed(ssum) > $signed(66'sh7FFFFFFFFFFF)) sat = {1'b0, {(VW-1){1'b1}}};
      else if ($signed(ssum) < -$signed(66'sh800000000000)) sat = {1'b1, {(VW-1){1'b0}}};
      else sat = ssum[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         rows_ff   <= ROWS_RESET;
         offset_ff <= OFFSET_RESET;
         clr_ff    <= '0;
         rsp_v_ff  <= 1'b0;
         iss_done_ff <= 1'b0;
         rd_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_index == REG_ROWS_IN_USE) rows_ff <= csr_data[7:0];
         if (csr_valid && csr_index == REG_LENGTH_OFFSET) offset_ff <= csr_data;
         if ((state_ff == ST_IDLE && req_acc && !req_tuser) ||
             (state_ff == ST_DONE && rsp_free)) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
         rd_v_ff <= (state_ff == ST_SCAN) && !iss_done_ff;
         unique case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            ST_IDLE: begin
               iss_ff      <= '0;
               iss_done_ff <= 1'b0;
               key_ff      <= req_tdata[ADDRW+2*VW-1:ADDRW+VW];
               if (req_acc && !req_tuser) begin
                  rsp_d_ff <= '0;
                  rsp_u_ff <= STATUS_WRITE;
               end
            end
            ST_SCAN: begin
               if (!iss_done_ff) begin
                  rd_i_ff <= iss_ff;
                  if (iss_ff == nlast) iss_done_ff <= 1'b1;
                  else iss_ff <= iss_ff + 1'b1;
               end
               if (rd_v_ff) begin
                  priority if (rd_i_ff == AW'(0)) begin
                     b_ff <= rd_i_ff; kb_ff <= mem_q_ff[VW-1:0]; db_ff <= key_dist;
                  end else if (rd_i_ff == AW'(1)) begin
                     s_ff <= rd_i_ff; ks_ff <= mem_q_ff[VW-1:0]; ds_ff <= key_dist;
                  end else if (key_dist < db_ff) begin
                     s_ff <= b_ff; ks_ff <= kb_ff; ds_ff <= db_ff;
                     b_ff <= rd_i_ff; kb_ff <= mem_q_ff[VW-1:0]; db_ff <= key_dist;
                  end else if (key_dist < ds_ff) begin
                     s_ff <= rd_i_ff; ks_ff <= mem_q_ff[VW-1:0]; ds_ff <= key_dist;
                  end
               end
            end
            ST_READB: ;
            ST_READS: vb_ff <= mem_q_ff[ROWW-1:VW];
            ST_LOADS: begin
               vs_ff   <= mem_q_ff[ROWW-1:VW];
               eq_ff   <= (kb_ff == ks_ff);
               fneg_ff <= num[VW] ^ den[VW];
               nsh_ff  <= num[VW] ? -num : num;
               dn_ff   <= den[VW] ? -den : den;
               r_ff    <= '0;
               q_ff    <= '0;
               ovf_ff  <= 1'b0;
               dcnt_ff <= 7'(DIVLAST);
               vidx_ff <= '0;
               step_ff <= '0;
            end
            ST_DIV: begin
               if (dcnt_ff >= 7'd32) nsh_ff <= {nsh_ff[VW-1:0], 1'b0};
               r_ff <= ge ? rt - {2'b0, dn_ff} : rt;
               if (ge && dcnt_ff >= 7'd63) ovf_ff <= 1'b1;
               if (dcnt_ff < 7'd63) q_ff <= {q_ff[QW-2:0], ge};
               dcnt_ff <= dcnt_ff - 1'b1;
            end
            ST_MUL: begin
               step_ff <= (step_ff == 3'd6) ? 3'd0 : step_ff + 1'b1;
               if (step_ff == 3'd0) begin
                  dvmag_ff <= dv[VW] ? -dv : dv;
                  dvneg_ff <= dv[VW];
                  acc_ff   <= '0;
               end
               if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
                  pp_ff  <= 64'(achunk) * 64'(bchunk);
                  psh_ff <= 2'(step_ff[0]) + 2'(step_ff[1]);
               end
               if (step_ff >= 3'd2 && step_ff <= 3'd5) acc_ff <= acc_ff + ppsh;
               if (step_ff == 3'd6) begin
                  res_ff[vidx_ff*VW +: VW] <= sat;
                  vidx_ff <= vidx_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_d_ff <= res_ff;
                  rsp_u_ff <= eq_ff ? STATUS_EQUAL : STATUS_INTERP;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
